[design/pubsub_line_frame_parser_macros.svh]
// Assertion macros shared by the parser top level.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef PUBSUB_LINE_FRAME_PARSER_MACROS_SVH
`define PUBSUB_LINE_FRAME_PARSER_MACROS_SVH

// Same-cycle implication
`define PSLFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PSLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pslfp_pkg.sv]
package pslfp_pkg;

    // Event codes
    localparam logic [2:0] EV_TEXT      = 3'd0;
    localparam logic [2:0] EV_TOKEN     = 3'd1;
    localparam logic [2:0] EV_PAYLOAD   = 3'd2;
    localparam logic [2:0] EV_CTRL_DONE = 3'd3;
    localparam logic [2:0] EV_HDR_OK    = 3'd4;
    localparam logic [2:0] EV_HDR_DROP  = 3'd5;
    localparam logic [2:0] EV_MSG_DONE  = 3'd6;

    // Frame kinds, also the keyword slots
    localparam logic [2:0] KIND_INFO = 3'd0;
    localparam logic [2:0] KIND_PING = 3'd1;
    localparam logic [2:0] KIND_PONG = 3'd2;
    localparam logic [2:0] KIND_OK   = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;
    localparam logic [2:0] KIND_MSG  = 3'd5;

    // Drop causes
    localparam logic [1:0] CAUSE_COUNT    = 2'd0;
    localparam logic [1:0] CAUSE_NO_DIGIT = 2'd1;
    localparam logic [1:0] CAUSE_OVERFLOW = 2'd2;

    // Size status bits
    localparam int ST_DIG  = 0;
    localparam int ST_STOP = 1;
    localparam int ST_OVF  = 2;

    // Characters
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Keyword table, padded to eight positions
    localparam int KW_NUM = 6;
    localparam logic [5:0] KW_ALL = 6'h3F;
    localparam logic [7:0] KW_TEXT [0:KW_NUM-1][0:7] = '{
        '{8'h49, 8'h4E, 8'h46, 8'h4F, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2B, 8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2D, 8'h45, 8'h52, 8'h52, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h53, 8'h47, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [0:KW_NUM-1] = '{3'd5, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4};

    // Result queue depth
    localparam int OQ_DEPTH = 4;

    // Parser mode
    typedef enum logic [6:0] {
        M_KEY       = 7'b0000001,
        M_TEXT_INFO = 7'b0000010,
        M_TEXT_ERR  = 7'b0000100,
        M_HDR       = 7'b0001000,
        M_DISCARD   = 7'b0010000,
        M_PAYLOAD   = 7'b0100000,
        M_TRAILER   = 7'b1000000
    } t_mode;

    // One result word
    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  frame_kind;
        logic [7:0]  data_byte;
        logic [1:0]  token_index;
        logic        has_reply;
        logic [31:0] payload_length;
        logic [1:0]  drop_cause;
        logic        last_of_run;
    } t_result;

    // Up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] n;
        t_result    q0;
        t_result    q1;
    } t_push;

    function automatic t_result f_result(input logic [2:0] ev, input logic [2:0] kind,
                                         input logic [7:0] data);
        t_result r;
        r = '0;
        r.event_res  = ev;
        r.frame_kind = kind;
        r.data_byte  = data;
        return r;
    endfunction

    function automatic logic f_is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

[design/pubsub_line_frame_parser.sv]
// Byte-serial parser for a CR LF line based publish/subscribe text protocol.
// One received byte is taken per cycle while the queue has room; each byte yields
// zero, one or two result words, and result words leave one per cycle while the
// receiver is ready, through a four-entry result queue, so the input sustains one
// byte per cycle as long as bytes make at most one result each (a held CR
// followed by a text byte makes two). Each byte sits in the input register, the
// whole per-byte parse runs between that register and the queue, and the queue
// head drives the outputs. Input ready drops only when the queue cannot take a
// full pair of results. LEN_BITS sets the width of the payload size counters
// (8 to 64); payload_length shows the low 32 bits.
`include "pubsub_line_frame_parser_macros.svh"

module pubsub_line_frame_parser #(
    parameter int LEN_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [2:0]  o_frame_kind,
    output logic [7:0]  o_data_byte,
    output logic [1:0]  o_token_index,
    output logic        o_has_reply,
    output logic [31:0] o_payload_length,
    output logic [1:0]  o_drop_cause,
    output logic        o_last_of_run
);
    import pslfp_pkg::*;

    t_push   w_push;
    logic    w_room;
    t_result w_res;
    logic    w_push_any;
    logic    w_open_pair;
    logic    w_text_word;
    logic    w_text_kind;
    logic    w_msg_word;

    // parse stage
    pslfp_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_room     (w_room),
        .o_push     (w_push)
    );

    // result queue
    pslfp_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_res)
    );

    assign o_event_res      = w_res.event_res;
    assign o_frame_kind     = w_res.frame_kind;
    assign o_data_byte      = w_res.data_byte;
    assign o_token_index    = w_res.token_index;
    assign o_has_reply      = w_res.has_reply;
    assign o_payload_length = w_res.payload_length;
    assign o_drop_cause     = w_res.drop_cause;
    assign o_last_of_run    = w_res.last_of_run;

    // checks
    assign w_push_any  = (w_push.n != 2'd0);
    assign w_open_pair = o_out_valid && !o_last_of_run;
    assign w_text_word = o_out_valid && (o_event_res == EV_TEXT);
    assign w_text_kind = (o_frame_kind == KIND_INFO) || (o_frame_kind == KIND_ERR);
    assign w_msg_word  = o_out_valid && ((o_event_res == EV_PAYLOAD)
                         || (o_event_res == EV_MSG_DONE) || (o_event_res == EV_TOKEN));

    `PSLFP_ASSERT_NOW(a_push_room, w_push_any, w_room, "results pushed into a full queue")
    `PSLFP_ASSERT_NEXT(a_pair_held, w_open_pair, o_out_valid, "second result missing")
    `PSLFP_ASSERT_NOW(a_text_kind, w_text_word, w_text_kind, "text word with bad kind")
    `PSLFP_ASSERT_NOW(a_msg_kind, w_msg_word, o_frame_kind == KIND_MSG, "message word with bad kind")

endmodule

[design/pslfp_ofifo.sv]
module pslfp_ofifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pslfp_pkg::t_push   i_push,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output pslfp_pkg::t_result o_res
);
    import pslfp_pkg::*;

    localparam int AW = $clog2(OQ_DEPTH);
    localparam int CW = AW + 1;

    t_result         r_mem [OQ_DEPTH];
    logic [AW-1:0]   r_head;
    logic [AW-1:0]   r_tail;
    logic [CW-1:0]   r_count;
    logic            w_pop;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_head];
    assign w_pop   = o_valid && i_ready;
    // room for a full pair of results
    assign o_room  = (r_count <= CW'(OQ_DEPTH - 2));

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_pop) begin
                r_head <= r_head + AW'(1);
            end
            r_tail  <= r_tail + AW'(i_push.n);
            r_count <= r_count + CW'(i_push.n) - CW'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_tail] <= i_push.q0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_tail + AW'(1)] <= i_push.q1;
        end
    end

endmodule

[design/pslfp_core.sv]
module pslfp_core #(
    parameter int LEN_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_room,
    output pslfp_pkg::t_push o_push
);
    import pslfp_pkg::*;

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

    typedef struct packed {
        t_mode                      mode;
        logic [2:0]                 kpos;
        logic [5:0]                 kcand;
        logic                       held;
        logic [2:0]                 tpos;
        logic                       intok;
        logic [1:0][LEN_BITS-1:0]   acc;
        logic [1:0][2:0]            st;
        logic [LEN_BITS-1:0]        prem;
        logic [1:0]                 trem;
    } t_lstate;

    typedef struct packed {
        t_lstate s;
        logic    emit;
        t_result r;
    } t_lstep;

    function automatic t_lstate f_start_line(input t_lstate s);
        t_lstate o;
        o       = s;
        o.mode  = M_KEY;
        o.kpos  = 3'd0;
        o.kcand = KW_ALL;
        o.held  = 1'b0;
        return o;
    endfunction

    // One byte of a line
    function automatic t_lstep f_line_byte(input t_lstate s, input logic [7:0] b);
        t_lstep                o;
        logic [5:0]            cand;
        logic [2:0]            pos;
        logic [2:0]            tp;
        logic [1:0]            idx;
        logic                  slot;
        logic [2:0]            st;
        logic [LEN_BITS+3:0]   acc_x;
        logic [LEN_BITS+3:0]   prod;
        int                    k;
        o      = '0;
        o.s    = s;
        o.emit = 1'b0;
        o.r    = f_result(EV_TEXT, KIND_INFO, 8'h00);
        cand   = s.kcand;
        pos    = s.kpos;
        tp     = s.tpos;
        idx    = 2'd0;
        slot   = 1'b0;
        st     = 3'd0;
        acc_x  = '0;
        prod   = '0;
        case (s.mode)
            M_KEY: begin
                for (k = 0; k < KW_NUM; k++) begin
                    if (cand[k] && !((s.kpos < KW_LEN[k]) && (b == KW_TEXT[k][s.kpos]))) begin
                        cand[k] = 1'b0;
                    end
                end
                if (s.kpos < 3'd7) begin
                    pos = s.kpos + 3'd1;
                end
                o.s.kcand = cand;
                o.s.kpos  = pos;
                if (cand[KIND_INFO] && (pos == 3'd5)) begin
                    o.s.mode = M_TEXT_INFO;
                end else if (cand[KIND_ERR] && (pos == 3'd5)) begin
                    o.s.mode = M_TEXT_ERR;
                end else if (cand[KIND_MSG] && (pos == 3'd4)) begin
                    o.s.mode  = M_HDR;
                    o.s.tpos  = 3'd0;
                    o.s.intok = 1'b0;
                    o.s.acc   = '0;
                    o.s.st    = '0;
                end else if (cand == 6'd0) begin
                    o.s.mode = M_DISCARD;
                end
            end
            M_TEXT_INFO: begin
                o.emit = 1'b1;
                o.r    = f_result(EV_TEXT, KIND_INFO, b);
            end
            M_TEXT_ERR: begin
                o.emit = 1'b1;
                o.r    = f_result(EV_TEXT, KIND_ERR, b);
            end
            M_HDR: begin
                if (f_is_space(b)) begin
                    o.s.intok = 1'b0;
                end else begin
                    if (!s.intok) begin
                        o.s.intok = 1'b1;
                        if (tp < 3'd5) begin
                            tp = tp + 3'd1;
                        end
                    end
                    o.s.tpos = tp;
                    // fifth and later tokens are swallowed
                    if (tp <= 3'd4) begin
                        idx           = 2'(tp - 3'd1);
                        o.emit        = 1'b1;
                        o.r           = f_result(EV_TOKEN, KIND_MSG, b);
                        o.r.token_index = idx;
                        // third and fourth tokens (index two and three) may carry the size
                        if (idx[1]) begin
                            slot = idx[0];
                            st   = s.st[slot];
                            if (!st[ST_STOP]) begin
                                if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
                                    if (!st[ST_OVF]) begin
                                        acc_x = {4'd0, s.acc[slot]};
                                        prod  = (acc_x << 3) + (acc_x << 1)
                                              + {{LEN_BITS{1'b0}}, b[3:0]};
                                        if (prod[LEN_BITS+3:LEN_BITS] != 4'd0) begin
                                            st[ST_OVF] = 1'b1;
                                        end else begin
                                            o.s.acc[slot] = prod[LEN_BITS-1:0];
                                        end
                                    end
                                    st[ST_DIG] = 1'b1;
                                end else begin
                                    st[ST_STOP] = 1'b1;
                                end
                                o.s.st[slot] = st;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    // CR LF seen: close the line
    function automatic t_lstep f_line_end(input t_lstate s);
        t_lstep                o;
        logic                  slot;
        logic                  accept;
        logic [LEN_BITS+31:0]  len_x;
        int                    k;
        o      = '0;
        o.s    = s;
        o.emit = 1'b0;
        o.r    = f_result(EV_CTRL_DONE, KIND_INFO, 8'h00);
        slot   = (s.tpos == 3'd4);
        accept = 1'b0;
        len_x  = {32'd0, s.acc[slot]};
        case (s.mode)
            M_KEY: begin
                for (k = int'(KIND_PING); k <= int'(KIND_OK); k++) begin
                    if (s.kcand[k] && (s.kpos == KW_LEN[k])) begin
                        o.emit = 1'b1;
                        o.r    = f_result(EV_CTRL_DONE, 3'(k), 8'h00);
                    end
                end
            end
            M_TEXT_INFO: begin
                o.emit = 1'b1;
                o.r    = f_result(EV_CTRL_DONE, KIND_INFO, 8'h00);
            end
            M_TEXT_ERR: begin
                o.emit = 1'b1;
                o.r    = f_result(EV_CTRL_DONE, KIND_ERR, 8'h00);
            end
            M_HDR: begin
                o.emit = 1'b1;
                o.r    = f_result(EV_HDR_DROP, KIND_MSG, 8'h00);
                if ((s.tpos < 3'd3) || (s.tpos > 3'd4)) begin
                    o.r.drop_cause = CAUSE_COUNT;
                end else if (!s.st[slot][ST_DIG]) begin
                    o.r.drop_cause = CAUSE_NO_DIGIT;
                end else if (s.st[slot][ST_OVF]) begin
                    o.r.drop_cause = CAUSE_OVERFLOW;
                end else begin
                    accept             = 1'b1;
                    o.r                = f_result(EV_HDR_OK, KIND_MSG, 8'h00);
                    o.r.has_reply      = slot;
                    o.r.payload_length = len_x[31:0];
                end
            end
            default: begin
            end
        endcase
        o.s = f_start_line(o.s);
        if (accept) begin
            o.s.prem = s.acc[slot];
            o.s.trem = 2'd2;
            o.s.mode = (s.acc[slot] != '0) ? M_PAYLOAD : M_TRAILER;
        end
        return o;
    endfunction

    t_lstate     r_st;
    t_lstate     n_st;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        w_consume;
    logic        w_e0;
    logic        w_e1;
    t_result     w_r0;
    t_result     w_r1;
    t_lstep      w_a;
    t_lstep      w_b;
    t_lstate     w_held_off;
    logic [1:0]  w_trem;

    assign w_consume  = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // byte step: at most two line steps, first one feeds the second
    always_comb begin
        w_held_off      = r_st;
        w_held_off.held = 1'b0;
        w_a             = f_line_byte(w_held_off, CH_CR);
        w_b             = f_line_byte(r_in_valid && r_st.held ? w_a.s : r_st, r_in_byte);
        w_trem          = (r_st.trem != 2'd0) ? (r_st.trem - 2'd1) : r_st.trem;
        n_st            = r_st;
        w_e0            = 1'b0;
        w_e1            = 1'b0;
        w_r0            = f_result(EV_TEXT, KIND_INFO, 8'h00);
        w_r1            = f_result(EV_TEXT, KIND_INFO, 8'h00);
        if (r_st.mode == M_PAYLOAD) begin
            w_e1      = 1'b1;
            w_r1      = f_result(EV_PAYLOAD, KIND_MSG, r_in_byte);
            n_st.prem = r_st.prem - LEN_ONE;
            if (r_st.prem == LEN_ONE) begin
                n_st.mode = M_TRAILER;
            end
        end else if (r_st.mode == M_TRAILER) begin
            n_st.trem = w_trem;
            if (w_trem == 2'd0) begin
                w_e1 = 1'b1;
                w_r1 = f_result(EV_MSG_DONE, KIND_MSG, 8'h00);
                n_st = f_start_line(n_st);
            end
        end else if (r_st.held) begin
            if (r_in_byte == CH_LF) begin
                n_st = f_line_end(w_held_off).s;
                w_e1 = f_line_end(w_held_off).emit;
                w_r1 = f_line_end(w_held_off).r;
            end else begin
                // held CR becomes a line byte
                w_e0 = w_a.emit;
                w_r0 = w_a.r;
                if (r_in_byte == CH_CR) begin
                    n_st      = w_a.s;
                    n_st.held = 1'b1;
                end else begin
                    n_st = w_b.s;
                    w_e1 = w_b.emit;
                    w_r1 = w_b.r;
                end
            end
        end else if (r_in_byte == CH_CR) begin
            n_st.held = 1'b1;
        end else begin
            n_st = w_b.s;
            w_e1 = w_b.emit;
            w_r1 = w_b.r;
        end
    end

    // pack results for the queue
    always_comb begin
        o_push                = '0;
        o_push.n              = w_consume ? ({1'b0, w_e0} + {1'b0, w_e1}) : 2'd0;
        o_push.q0             = w_e0 ? w_r0 : w_r1;
        o_push.q0.last_of_run = !(w_e0 && w_e1);
        o_push.q1             = w_r1;
        o_push.q1.last_of_run = 1'b1;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= f_start_line('0);
        end else if (w_consume) begin
            r_st <= n_st;
        end
    end

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pslfp_pkg::*;

    localparam int          LEN_BITS      = 32;
    localparam logic [63:0] SIZE_MAX      = (64'd1 << LEN_BITS) - 64'd1;
    localparam int          RX_BYTE_GOAL  = 1950;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          STALL_LIMIT   = 2000;
    localparam logic [7:0]  CH_VT         = 8'h0B;
    localparam logic [7:0]  CH_FF         = 8'h0C;
    localparam logic [7:0]  BLANKS [5]    = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_LF};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [2:0]  o_frame_kind;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_token_index;
    logic        o_has_reply;
    logic [31:0] o_payload_length;
    logic [1:0]  o_drop_cause;
    logic        o_last_of_run;

    // Token separators of the header line
    function automatic bit is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // Parser shadow plus the queue of result words it still expects
    class frame_scoreboard;
        t_mode       mode;
        logic [2:0]  kw_pos;
        logic [5:0]  kw_live;
        bit          cr_held;
        logic [2:0]  tok_count;
        bit          in_token;
        logic [63:0] size_acc [2];
        logic [2:0]  size_flags [2];
        logic [63:0] payload_left;
        logic [1:0]  trailer_left;
        t_result     expected_words [$];
        int          errors;

        function new();
            restart_line();
            tok_count    = '0;
            in_token     = 1'b0;
            size_acc     = '{64'd0, 64'd0};
            size_flags   = '{3'd0, 3'd0};
            payload_left = '0;
            trailer_left = '0;
            errors       = 0;
        endfunction

        function void restart_line();
            mode    = M_KEY;
            kw_pos  = '0;
            kw_live = KW_ALL;
            cr_held = 1'b0;
        endfunction

        function void emit_word(logic [2:0] ev, logic [2:0] kind, logic [7:0] data = '0,
                                logic [1:0] tok = '0, logic reply = 1'b0,
                                logic [31:0] len = '0, logic [1:0] cause = '0);
            t_result r;
            r                = '0;
            r.event_res      = ev;
            r.frame_kind     = kind;
            r.data_byte      = data;
            r.token_index    = tok;
            r.has_reply      = reply;
            r.payload_length = len;
            r.drop_cause     = cause;
            expected_words   = {expected_words, r};
        endfunction

        // One byte that belongs to the current line
        function void take_line_byte(logic [7:0] b);
            logic [1:0]  idx;
            int          s;
            logic [63:0] d;
            case (mode)
                M_KEY: begin
                    for (int k = 0; k < KW_NUM; k++) begin
                        if (kw_live[k] && !(kw_pos < KW_LEN[k] && b == KW_TEXT[k][kw_pos]))
                            kw_live[k] = 1'b0;
                    end
                    if (kw_pos < 3'd7)
                        kw_pos++;
                    if (kw_live[KIND_INFO] && kw_pos == 3'd5) begin
                        mode = M_TEXT_INFO;
                    end else if (kw_live[KIND_ERR] && kw_pos == 3'd5) begin
                        mode = M_TEXT_ERR;
                    end else if (kw_live[KIND_MSG] && kw_pos == 3'd4) begin
                        mode       = M_HDR;
                        tok_count  = '0;
                        in_token   = 1'b0;
                        size_acc   = '{64'd0, 64'd0};
                        size_flags = '{3'd0, 3'd0};
                    end else if (kw_live == '0) begin
                        mode = M_DISCARD;
                    end
                end
                M_TEXT_INFO: emit_word(EV_TEXT, KIND_INFO, b);
                M_TEXT_ERR:  emit_word(EV_TEXT, KIND_ERR, b);
                M_HDR: begin
                    if (is_blank(b)) begin
                        in_token = 1'b0;
                    end else begin
                        if (!in_token) begin
                            in_token = 1'b1;
                            if (tok_count < 3'd5)
                                tok_count++;
                        end
                        // fifth and later tokens are swallowed
                        if (tok_count <= 3'd4) begin
                            idx = 2'(tok_count - 3'd1);
                            emit_word(EV_TOKEN, KIND_MSG, b, idx);
                            if (idx >= 2'd2) begin
                                s = idx - 2;
                                if (!size_flags[s][ST_STOP]) begin
                                    if (b >= CH_ZERO && b <= CH_NINE) begin
                                        d = 64'(b - CH_ZERO);
                                        if (!size_flags[s][ST_OVF]) begin
                                            if (size_acc[s] > (SIZE_MAX - d) / 64'd10)
                                                size_flags[s][ST_OVF] = 1'b1;
                                            else
                                                size_acc[s] = size_acc[s] * 64'd10 + d;
                                        end
                                        size_flags[s][ST_DIG] = 1'b1;
                                    end else begin
                                        size_flags[s][ST_STOP] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // CR LF seen: close the line
        function void close_line();
            int slot;
            case (mode)
                M_KEY: begin
                    for (int k = KIND_PING; k <= KIND_OK; k++) begin
                        if (kw_live[k] && kw_pos == KW_LEN[k])
                            emit_word(EV_CTRL_DONE, 3'(k));
                    end
                end
                M_TEXT_INFO: emit_word(EV_CTRL_DONE, KIND_INFO);
                M_TEXT_ERR:  emit_word(EV_CTRL_DONE, KIND_ERR);
                M_HDR: begin
                    slot = (tok_count == 3'd4) ? 1 : 0;
                    if (tok_count < 3'd3 || tok_count > 3'd4) begin
                        emit_word(EV_HDR_DROP, KIND_MSG, '0, '0, 1'b0, '0, CAUSE_COUNT);
                    end else if (!size_flags[slot][ST_DIG]) begin
                        emit_word(EV_HDR_DROP, KIND_MSG, '0, '0, 1'b0, '0, CAUSE_NO_DIGIT);
                    end else if (size_flags[slot][ST_OVF]) begin
                        emit_word(EV_HDR_DROP, KIND_MSG, '0, '0, 1'b0, '0, CAUSE_OVERFLOW);
                    end else begin
                        emit_word(EV_HDR_OK, KIND_MSG, '0, '0, 1'(slot), size_acc[slot][31:0]);
                        payload_left = size_acc[slot];
                        trailer_left = 2'd2;
                        restart_line();
                        mode = (payload_left != '0) ? M_PAYLOAD : M_TRAILER;
                        return;
                    end
                end
                default: ;
            endcase
            restart_line();
        endfunction

        // Accepted input byte: queue up the words it should produce
        function void note_rx_byte(logic [7:0] b);
            int first;
            first = expected_words.size();
            if (mode == M_PAYLOAD) begin
                emit_word(EV_PAYLOAD, KIND_MSG, b);
                payload_left--;
                if (payload_left == '0)
                    mode = M_TRAILER;
            end else if (mode == M_TRAILER) begin
                if (trailer_left > 2'd0)
                    trailer_left--;
                if (trailer_left == 2'd0) begin
                    emit_word(EV_MSG_DONE, KIND_MSG);
                    restart_line();
                end
            end else if (cr_held) begin
                cr_held = 1'b0;
                if (b == CH_LF) begin
                    close_line();
                end else begin
                    // lone CR counts as a line byte
                    take_line_byte(CH_CR);
                    if (b == CH_CR)
                        cr_held = 1'b1;
                    else
                        take_line_byte(b);
                end
            end else if (b == CH_CR) begin
                cr_held = 1'b1;
            end else begin
                take_line_byte(b);
            end
            if (expected_words.size() > first)
                expected_words[expected_words.size() - 1].last_of_run = 1'b1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                $error("result word with nothing pending: event %0d kind %0d data %0h",
                       got.event_res, got.frame_kind, got.data_byte);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
            compare_field("frame_kind", 32'(want.frame_kind), 32'(got.frame_kind));
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("token_index", 32'(want.token_index), 32'(got.token_index));
            compare_field("has_reply", 32'(want.has_reply), 32'(got.has_reply));
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("drop_cause", 32'(want.drop_cause), 32'(got.drop_cause));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        endfunction
    endclass

    frame_scoreboard parse_check = new();

    logic [7:0] frame_q [$];
    int         bytes_sent = 0;
    bit         tx_quiet = 1'b0;
    bit         rx_quiet = 1'b0;
    bit         hold_req = 1'b0;

    pubsub_line_frame_parser #(
        .LEN_BITS(LEN_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_event_res      (o_event_res),
        .o_frame_kind     (o_frame_kind),
        .o_data_byte      (o_data_byte),
        .o_token_index    (o_token_index),
        .o_has_reply      (o_has_reply),
        .o_payload_length (o_payload_length),
        .o_drop_cause     (o_drop_cause),
        .o_last_of_run    (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Frame assembly
    task automatic put_byte(logic [7:0] b);
        frame_q = {frame_q, b};
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    task automatic put_line(string s);
        put_str(s);
        put_crlf();
    endtask

    task automatic put_token();
        logic [7:0] c;
        repeat ($urandom_range(1, 6)) begin
            do c = 8'($urandom_range(0, 255)); while (is_blank(c));
            put_byte(c);
        end
    endtask

    // Separator run; a lone CR only where a token byte follows
    task automatic put_gap(bit allow_cr);
        if (allow_cr && $urandom_range(0, 7) == 0) begin
            put_byte(CH_CR);
        end else begin
            repeat ($urandom_range(1, 2))
                put_byte(BLANKS[$urandom_range(0, 4)]);
        end
    endtask

    // MSG header; shape 0 good, 1 bad count, 2 size not numeric, 3 size overflow
    task automatic put_msg(int shape);
        int         ntok;
        int         len;
        logic [7:0] c;
        len = 0;
        put_str("MSG ");
        if ($urandom_range(0, 3) == 0)
            put_gap(1'b0);
        ntok = $urandom_range(0, 1) ? 4 : 3;
        if (shape == 1)
            ntok = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(5, 6);
        for (int t = 0; t < ntok - 1; t++) begin
            put_token();
            put_gap(1'b1);
        end
        if (ntok > 0) begin
            case (shape)
                0: begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300)
                                                      : $urandom_range(0, 16);
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
                    put_str($sformatf("%0d", len));
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 3)) put_byte(8'(8'h61 + $urandom_range(0, 25)));
                end
                2: begin
                    do c = 8'($urandom_range(0, 255));
                    while (is_blank(c) || (c >= CH_ZERO && c <= CH_NINE));
                    put_byte(c);
                    if ($urandom_range(0, 1))
                        put_str("12");
                end
                3: begin
                    if ($urandom_range(0, 1)) begin
                        put_str("4294967296");
                    end else begin
                        put_byte(8'(CH_ZERO + $urandom_range(1, 9)));
                        repeat ($urandom_range(10, 13))
                            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                    end
                end
                default: put_token();
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            put_gap(1'b0);
        put_crlf();
        if (shape == 0) begin
            repeat (len) put_byte(8'($urandom_range(0, 255)));
            repeat (2) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic put_random_frame();
        int pick;
        int base;
        pick = $urandom_range(0, 19);
        base = frame_q.size();
        if (pick < 8) begin
            put_msg(0);
        end else if (pick < 11) begin
            put_msg($urandom_range(1, 3));
        end else if (pick < 14) begin
            // control line, sometimes with one byte spoiled
            case ($urandom_range(0, 2))
                0:       put_str("PING");
                1:       put_str("PONG");
                default: put_str("+OK");
            endcase
            if ($urandom_range(0, 3) == 0)
                frame_q[base + $urandom_range(0, frame_q.size() - base - 1)]
                    = 8'($urandom_range(0, 255));
            put_crlf();
        end else if (pick < 17) begin
            put_str($urandom_range(0, 1) ? "INFO " : "-ERR ");
            if ($urandom_range(0, 5) == 0)
                frame_q[base + $urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            repeat ($urandom_range(0, 24)) put_byte(8'($urandom_range(0, 255)));
            put_crlf();
        end else begin
            repeat ($urandom_range(0, 10)) put_byte(8'($urandom_range(0, 255)));
            put_crlf();
        end
    endtask

    // Sender: one word per handshake, random gap ahead of each
    task automatic send_byte(logic [7:0] b);
        int gap;
        if (bytes_sent % 64 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_check.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        while (frame_q.size() > 0)
            send_byte(frame_q.pop_front());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (parse_check.expected_words.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall per word, one long hold when asked
    initial begin
        int      stall;
        int      words;
        t_result got;
        words = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (words % 64 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.event_res      = o_event_res;
            got.frame_kind     = o_frame_kind;
            got.data_byte      = o_data_byte;
            got.token_index    = o_token_index;
            got.has_reply      = o_has_reply;
            got.payload_length = o_payload_length;
            got.drop_cause     = o_drop_cause;
            got.last_of_run    = o_last_of_run;
            parse_check.check_word(got);
            words++;
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle = 0;
            end else begin
                idle++;
                if (idle >= STALL_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // Stimulus
    initial begin
        bit hold_issued;
        bit pause_done;
        hold_issued = 1'b0;
        pause_done  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // control lines, exact and near misses
        put_line("PING");
        put_line("PONG");
        put_line("+OK");
        put_line("INFO {x:1}");
        put_str("-ERR ");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_crlf();
        put_crlf();
        put_line("PINGX");
        put_line("PIN");
        put_line("INFO");
        put_line("HELLO");
        // CR without LF in text, lone LF, CR CR LF
        put_str("INFO a");
        put_byte(CH_CR);
        put_str("b");
        put_byte(CH_LF);
        put_str("c");
        put_byte(CH_CR);
        put_crlf();
        put_str("PING");
        put_byte(CH_CR);
        put_crlf();
        // headers: plain, reply with mixed blanks and junk after size, zero size
        put_line("MSG foo 1 5");
        put_str("hello");
        put_crlf();
        put_str("MSG  s");
        put_byte(CH_TAB);
        put_str("22");
        put_byte(CH_VT);
        put_str("r");
        put_byte(CH_FF);
        put_str("3xyz");
        put_crlf();
        put_str("abczz");
        put_line("MSG a b 0");
        put_str("QQ");
        // payload bytes that look like line ends
        put_line("MSG a b 00004");
        put_crlf();
        put_crlf();
        put_crlf();
        // lone CR and lone LF as separators
        put_str("MSG a");
        put_byte(CH_CR);
        put_str("b 2");
        put_crlf();
        put_str("xy");
        put_crlf();
        put_str("MSG a");
        put_byte(CH_LF);
        put_str("b 1");
        put_crlf();
        put_str("!");
        put_crlf();
        // dropped headers
        put_line("MSG");
        put_line("MSG ");
        put_line("MSG a b");
        put_line("MSG a b c d e f");
        put_line("MSG a b -3");
        put_line("MSG a b 4294967296");
        put_line("MSG a b c 99999999999");
        send_frame();

        // random frames
        while (bytes_sent < RX_BYTE_GOAL) begin
            put_random_frame();
            send_frame();
            if (!hold_issued && bytes_sent > 600) begin
                hold_req    = 1'b1;
                hold_issued = 1'b1;
            end
            if (!pause_done && bytes_sent > 1200) begin
                wait_drained();
                repeat (DRAIN_CYCLES) @(posedge i_clk);
                pause_done = 1'b1;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (parse_check.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[pubsub_line_frame_parser.f]
+incdir+design
design/pslfp_pkg.sv
design/pslfp_ofifo.sv
design/pslfp_core.sv
design/pubsub_line_frame_parser.sv
test/tb.sv
